### rtl/absm_pkg.sv
// ----------------------------------------------------------------------------
// absm_pkg
// Shared types and constants for the ambient auto-brightness smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package absm_pkg;

   localparam int TIME_W     = 32;
   localparam int LUX_W      = 16;
   localparam int LEVEL_W    = 8;
   localparam int FRAC_BITS  = 16;
   localparam int SMOOTH_W   = LEVEL_W + FRAC_BITS;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_MIN    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_MAX    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LUX_MAX     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL_MS = 4'd3;

   // Configuration reset values.
   localparam logic [LEVEL_W-1:0] AUTO_MIN_RESET    = 8'd10;
   localparam logic [LEVEL_W-1:0] AUTO_MAX_RESET    = 8'd255;
   localparam logic [LUX_W-1:0]   LUX_MAX_RESET     = 16'd1000;
   localparam logic [15:0]        INTERVAL_MS_RESET = 16'd1000;

   localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = 8'd128;

   // Filter factor 0.1 in Q0.16, as a signed operand.
   localparam int GAIN_W = 14;
   localparam logic signed [GAIN_W-1:0] FILTER_GAIN = 14'sd6554;

   // Long division of a 40-bit dividend, one quotient bit per step.
   localparam int DIV_STEPS  = LEVEL_W + LUX_W + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [LUX_W-1:0]   lux;
      logic               auto_mode;
      logic [LEVEL_W-1:0] manual_level;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LUX_W-1:0]   last_lux;
      logic               measured;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic filt;
      logic update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic measure;
      logic use_div;
   } stat_type;

endpackage

`default_nettype wire

### rtl/absm_ctrl.sv
// ----------------------------------------------------------------------------
// absm_ctrl
// Sequencer for the smoother: handshakes, division step count and the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module absm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire absm_pkg::stat_type stat,
   output      absm_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FILT = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam logic [absm_pkg::DIV_CNT_W-1:0] DIV_LAST =
      absm_pkg::DIV_CNT_W'(absm_pkg::DIV_STEPS - 1);

   logic [2:0]                       state_ff, state_in;
   logic [absm_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            if (!stat.measure) begin
               state_in = S_DONE;
            end else if (stat.use_div) begin
               state_in = S_DIV;
            end else begin
               state_in = S_FILT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               div_cnt_in = '0;
               state_in   = S_FILT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_FILT: begin
            cmd.filt = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in   = S_IDLE;
            div_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted transaction always starts with the multiply step.
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL))
      else $error("accepted transaction did not enter the multiply step");

   // The step counter only runs during division.
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (div_cnt_ff == '0))
      else $error("division counter nonzero outside division");

   // A result is never written over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while still pending");

   // A finished item waits while the output is blocked.
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("finished item left while output was stalled");

endmodule

`default_nettype wire

### rtl/absm_datapath.sv
// ----------------------------------------------------------------------------
// absm_datapath
// Configuration registers, interval check, target mapping with a shift and
// subtract divider, the low-pass filter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module absm_datapath #(
   parameter logic [absm_pkg::LEVEL_W-1:0] DEFAULT_LEVEL = absm_pkg::DEFAULT_LEVEL
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [absm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [absm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire absm_pkg::req_type                   req_data,
   input  wire absm_pkg::cmd_type                   cmd,
   output      absm_pkg::stat_type                  stat,
   output      absm_pkg::rsp_type                   rsp_data
);

   localparam int LW  = absm_pkg::LEVEL_W;
   localparam int XW  = absm_pkg::LUX_W;
   localparam int FB  = absm_pkg::FRAC_BITS;
   localparam int SW  = absm_pkg::SMOOTH_W;
   localparam int TW  = absm_pkg::TIME_W;
   localparam int DW  = absm_pkg::DIV_STEPS;
   localparam int PW  = SW + 1 + absm_pkg::GAIN_W;

   // Configuration.
   logic [LW-1:0] auto_min_ff, auto_max_ff;
   logic [XW-1:0] lux_max_ff;
   logic [15:0]   interval_ff;

   // Architectural state.
   logic [SW-1:0] smooth_ff, smooth_in;
   logic [TW-1:0] last_time_ff;
   logic [XW-1:0] held_lux_ff;
   logic [LW-1:0] rounded_ff, rounded_in;

   // Captured transaction.
   logic [TW-1:0] now_ff;
   logic [XW-1:0] lux_ff;
   logic          auto_ff;
   logic [LW-1:0] manual_ff;
   logic          meas_ff;

   // Divider and filter work registers.
   logic [DW-1:0] div_work_ff;
   logic [XW-1:0] div_rem_ff;
   logic signed [PW-1:0] prod_ff;

   absm_pkg::rsp_type rsp_ff;

   logic [TW-1:0]         elapsed;
   logic                  meas_in;
   logic                  span_neg;
   logic [LW-1:0]         span_abs;
   logic [XW-1:0]         lux_clamp;
   logic [LW+XW-1:0]      mul_prod;
   logic [XW:0]           trial;
   logic                  trial_ok;
   logic [SW-1:0]         base;
   logic [SW-1:0]         quot;
   logic [SW-1:0]         target;
   logic signed [SW:0]    diff;
   logic signed [PW-1:0]  prod_in;
   logic signed [SW+1:0]  s_sum;
   logic [SW:0]           round_sum;

   assign elapsed = req_data.now_ms - last_time_ff;
   assign meas_in = (elapsed >= {{(TW-16){1'b0}}, interval_ff});

   assign stat.measure = meas_ff;
   assign stat.use_div = auto_ff && (lux_max_ff != '0);

   assign span_neg  = (auto_max_ff < auto_min_ff);
   assign span_abs  = span_neg ? (auto_min_ff - auto_max_ff) : (auto_max_ff - auto_min_ff);
   assign lux_clamp = (lux_ff < lux_max_ff) ? lux_ff : lux_max_ff;
   assign mul_prod  = lux_clamp * span_abs;

   assign trial    = {div_rem_ff, div_work_ff[DW-1]};
   assign trial_ok = (trial >= {1'b0, lux_max_ff});

   // The quotient never exceeds the span in Q8.16, so its low bits suffice.
   assign base = {auto_min_ff, {FB{1'b0}}};
   assign quot = div_work_ff[SW-1:0];

   always_comb begin
      if (!auto_ff) begin
         target = {manual_ff, {FB{1'b0}}};
      end else if (lux_max_ff == '0) begin
         target = {auto_max_ff, {FB{1'b0}}};
      end else if (span_neg) begin
         target = base - quot;
      end else begin
         target = base + quot;
      end
   end

   assign diff    = $signed({1'b0, target}) - $signed({1'b0, smooth_ff});
   assign prod_in = diff * absm_pkg::FILTER_GAIN;

   // Arithmetic shift of the product gives the floored filter step.
   assign s_sum = $signed({2'b00, smooth_ff})
                + $signed({{(SW+2-(PW-FB)){prod_ff[PW-1]}}, prod_ff[PW-1:FB]});

   always_comb begin
      if (s_sum[SW+1]) begin
         smooth_in = '0;
      end else if (s_sum[SW]) begin
         smooth_in = '1;
      end else begin
         smooth_in = s_sum[SW-1:0];
      end
      round_sum  = {1'b0, smooth_in} + (SW+1)'(1 << (FB - 1));
      rounded_in = round_sum[SW] ? '1 : round_sum[SW-1:FB];
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_min_ff <= absm_pkg::AUTO_MIN_RESET;
         auto_max_ff <= absm_pkg::AUTO_MAX_RESET;
         lux_max_ff  <= absm_pkg::LUX_MAX_RESET;
         interval_ff <= absm_pkg::INTERVAL_MS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            absm_pkg::REG_AUTO_MIN:    auto_min_ff <= csr_data[LW-1:0];
            absm_pkg::REG_AUTO_MAX:    auto_max_ff <= csr_data[LW-1:0];
            absm_pkg::REG_LUX_MAX:     lux_max_ff  <= csr_data[XW-1:0];
            absm_pkg::REG_INTERVAL_MS: interval_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= {DEFAULT_LEVEL, {FB{1'b0}}};
         last_time_ff <= '0;
         held_lux_ff  <= '0;
         rounded_ff   <= DEFAULT_LEVEL;
      end else if (cmd.update) begin
         smooth_ff    <= smooth_in;
         last_time_ff <= now_ff;
         rounded_ff   <= rounded_in;
         if (auto_ff) begin
            held_lux_ff <= lux_ff;
         end
      end
   end

   // Work registers, no reset needed.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff    <= req_data.now_ms;
         lux_ff    <= req_data.lux;
         auto_ff   <= req_data.auto_mode;
         manual_ff <= req_data.manual_level;
         meas_ff   <= meas_in;
      end
      if (cmd.mul) begin
         div_work_ff <= {mul_prod, {FB{1'b0}}};
         div_rem_ff  <= '0;
      end else if (cmd.div_step) begin
         div_work_ff <= {div_work_ff[DW-2:0], trial_ok};
         div_rem_ff  <= trial_ok ? XW'(trial - {1'b0, lux_max_ff}) : trial[XW-1:0];
      end
      if (cmd.filt) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         rsp_ff.level    <= rounded_ff;
         rsp_ff.last_lux <= held_lux_ff;
         rsp_ff.measured <= meas_ff;
      end
   end

   assign rsp_data = rsp_ff;

   // The divider remainder always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (div_rem_ff < lux_max_ff))
      else $error("divider remainder not below divisor");

   // Without a measurement the filter state is left alone.
   a_no_meas_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !meas_ff) |-> ($stable(smooth_ff) && $stable(last_time_ff)))
      else $error("filter state changed for an unmeasured item");

   // The rounded level follows the stored filter value.
   a_round_match: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (rounded_ff == ((smooth_ff[SW-1:FB] == '1 && smooth_ff[FB-1])
                       ? {LW{1'b1}} : LW'(smooth_ff[SW-1:FB] + smooth_ff[FB-1]))))
      else $error("rounded level disagrees with filter value");

endmodule

`default_nettype wire

### rtl/ambient_auto_brightness_smoother.sv
// ----------------------------------------------------------------------------
// ambient_auto_brightness_smoother
// Maps a lux reading or a manual level to a target brightness and smooths it
// with a first-order low-pass filter, at most once per configured interval.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   req       req_valid/req_ready    req_data  (now_ms, lux, auto_mode, manual_level)
//   rsp       rsp_valid/rsp_ready    rsp_data  (level, last_lux, measured)
//   csr       csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One transaction is in flight at a time. A measured auto-mode item passes the
// multiply, the 40-step shift and subtract divider, the filter and the update
// step before rsp_valid rises, together with req_ready. Manual mode or a zero
// lux_max skips the divider; an item inside the interval skips filter and update too.
// A new request is accepted while a finished result waits in the output register;
// a stalled output holds the next item at its last step. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_auto_brightness_smoother #(
   parameter logic [absm_pkg::LEVEL_W-1:0] DEFAULT_LEVEL = absm_pkg::DEFAULT_LEVEL
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire absm_pkg::req_type                  req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      absm_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [absm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [absm_pkg::CSR_DATA_W-1:0]    csr_data
);

   absm_pkg::cmd_type  cmd;
   absm_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   absm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   absm_datapath #(
      .DEFAULT_LEVEL (DEFAULT_LEVEL)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/brightness_checker.sv
// ----------------------------------------------------------------------------
// brightness_checker
// Watches the request, result and register channels of the brightness
// smoother, predicts every result from its own copy of the filter state and
// the register settings, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module brightness_checker
   import absm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          mismatches,
   output int                          outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [LEVEL_W-1:0]  cfg_auto_min;
   logic [LEVEL_W-1:0]  cfg_auto_max;
   logic [LUX_W-1:0]    cfg_lux_max;
   logic [15:0]         cfg_interval;

   logic [SMOOTH_W-1:0] smooth_q;
   logic [TIME_W-1:0]   last_time;
   logic [LUX_W-1:0]    held_lux;
   logic [LEVEL_W-1:0]  level_q;

   rsp_type expected_levels[$];

   // Auto-mode target in Q8.16; the magnitude of the slope term is truncated.
   function automatic longint auto_target_q16(input logic [LUX_W-1:0] lux);
      longint base;
      longint span;
      longint c;
      longint mag;
      base = longint'(cfg_auto_min) << FRAC_BITS;
      if (cfg_lux_max == '0)
         return longint'(cfg_auto_max) << FRAC_BITS;
      c = (lux < cfg_lux_max) ? longint'(lux) : longint'(cfg_lux_max);
      span = longint'(cfg_auto_max) - longint'(cfg_auto_min);
      mag = ((c * ((span < 0) ? -span : span)) << FRAC_BITS) / longint'(cfg_lux_max);
      return (span < 0) ? base - mag : base + mag;
   endfunction

   function automatic rsp_type predict_brightness(input req_type item);
      longint target;
      longint s;
      logic [TIME_W-1:0] elapsed;
      logic [SMOOTH_W:0] rounded;
      rsp_type res;
      res.measured = 1'b0;
      elapsed = item.now_ms - last_time;
      if (elapsed >= cfg_interval) begin
         last_time = item.now_ms;
         res.measured = 1'b1;
         if (item.auto_mode) begin
            held_lux = item.lux;
            target = auto_target_q16(item.lux);
         end else begin
            target = longint'(item.manual_level) << FRAC_BITS;
         end
         // The arithmetic shift floors negative steps toward minus infinity.
         s = longint'(smooth_q);
         s = s + (((target - s) * longint'(FILTER_GAIN)) >>> FRAC_BITS);
         if (s < 0)
            s = 0;
         else if (s > 16777215)
            s = 16777215;
         smooth_q = s[SMOOTH_W-1:0];
         rounded = {1'b0, smooth_q} + 25'h8000;
         if (rounded[SMOOTH_W:FRAC_BITS] > 9'd255)
            level_q = 8'hFF;
         else
            level_q = rounded[SMOOTH_W-1:FRAC_BITS];
      end
      res.level = level_q;
      res.last_lux = held_lux;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_auto_min = AUTO_MIN_RESET;
         cfg_auto_max = AUTO_MAX_RESET;
         cfg_lux_max = LUX_MAX_RESET;
         cfg_interval = INTERVAL_MS_RESET;
         smooth_q = {DEFAULT_LEVEL, {FRAC_BITS{1'b0}}};
         last_time = '0;
         held_lux = '0;
         level_q = DEFAULT_LEVEL;
         expected_levels.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_AUTO_MIN:    cfg_auto_min = csr_data[LEVEL_W-1:0];
               REG_AUTO_MAX:    cfg_auto_max = csr_data[LEVEL_W-1:0];
               REG_LUX_MAX:     cfg_lux_max = csr_data[LUX_W-1:0];
               REG_INTERVAL_MS: cfg_interval = csr_data;
               default: ;
            endcase
         end
         // A result can never belong to a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected result level=%0d last_lux=%0d measured=%0b",
                           $realtime, rsp_data.level, rsp_data.last_lux, rsp_data.measured);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_data.level !== want.level || rsp_data.last_lux !== want.last_lux ||
                   rsp_data.measured !== want.measured) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%t: result mismatch: level exp %0d got %0d, ",
                               "last_lux exp %0d got %0d, measured exp %0b got %0b"},
                              $realtime, want.level, rsp_data.level, want.last_lux,
                              rsp_data.last_lux, want.measured, rsp_data.measured);
               end
            end
         end
         if (req_valid && req_ready)
            expected_levels.push_back(predict_brightness(req_data));
         outstanding <= expected_levels.size();
      end
   end

endmodule

`default_nettype wire

### tb/ambient_auto_brightness_smoother_test.sv
// ----------------------------------------------------------------------------
// ambient_auto_brightness_smoother_test
// Drives directed and random brightness requests and register settings into
// the smoother under varying sender and receiver idling, and reports the
// verdict from the result checker.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_auto_brightness_smoother_test;

   timeunit 1ns;
   timeprecision 1ps;

   import absm_pkg::*;

   localparam int RANDOM_BLOCKS = 9;
   localparam int BLOCK_ITEMS   = 150;
   localparam int LONG_STALL    = 400;
   localparam int TAIL_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 600000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left = 0;
   logic stall_toggle = 1'b0;
   logic stall_seen = 1'b0;

   logic [TIME_W-1:0] now_ms = '0;
   logic [15:0]       cur_interval = INTERVAL_MS_RESET;
   logic [LUX_W-1:0]  cur_lux_max = LUX_MAX_RESET;

   ambient_auto_brightness_smoother uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   brightness_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Each toggle of stall_toggle starts one long hold-off of the result channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_toggle != stall_seen) begin
         stall_seen <= stall_toggle;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic req_type make_item(input logic [TIME_W-1:0] t, input logic [LUX_W-1:0] lux,
                                         input logic auto_on, input logic [LEVEL_W-1:0] manual);
      req_type item;
      item.now_ms = t;
      item.lux = lux;
      item.auto_mode = auto_on;
      item.manual_level = manual;
      return item;
   endfunction

   // Valid stays high from one transaction to the next unless an idle gap is drawn.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic write_config(input logic [LEVEL_W-1:0] amin, input logic [LEVEL_W-1:0] amax,
                               input logic [LUX_W-1:0] lmax, input logic [15:0] ival);
      put_reg(REG_AUTO_MIN, {8'h00, amin});
      put_reg(REG_AUTO_MAX, {8'h00, amax});
      put_reg(REG_LUX_MAX, lmax);
      put_reg(REG_INTERVAL_MS, ival);
      csr_valid <= 1'b0;
      cur_lux_max = lmax;
      cur_interval = ival;
   endtask

   task automatic random_config();
      logic [LEVEL_W-1:0] amin;
      logic [LEVEL_W-1:0] amax;
      logic [LUX_W-1:0]   lmax;
      logic [15:0]        ival;
      case ($urandom_range(3))
         0: amin = 8'd0;
         1: amin = 8'd255;
         default: amin = LEVEL_W'($urandom_range(255));
      endcase
      case ($urandom_range(3))
         0: amax = 8'd0;
         1: amax = 8'd255;
         default: amax = LEVEL_W'($urandom_range(255));
      endcase
      case ($urandom_range(4))
         0: lmax = 16'd0;
         1: lmax = 16'd1;
         2: lmax = 16'hFFFF;
         3: lmax = LUX_W'($urandom_range(2000, 1));
         default: lmax = LUX_W'($urandom_range(65535));
      endcase
      case ($urandom_range(4))
         0: ival = 16'd0;
         1: ival = 16'($urandom_range(20, 1));
         2: ival = 16'($urandom_range(2000, 20));
         3: ival = 16'hFFFF;
         default: ival = 16'($urandom_range(65535));
      endcase
      write_config(amin, amax, lmax, ival);
   endtask

   // Time mostly steps around the interval so that both outcomes stay common.
   task automatic random_item(output req_type item);
      int unsigned pick;
      logic [LUX_W-1:0] lux;
      pick = $urandom_range(99);
      if (pick < 8)
         now_ms = $urandom;
      else if (pick < 55)
         now_ms = now_ms + 32'(cur_interval)
                + $urandom_range(32'(cur_interval) / 32'd8 + 32'd2);
      else if (pick < 80)
         now_ms = now_ms + $urandom_range(32'(cur_interval));
      else
         now_ms = now_ms + $urandom_range(3);
      case ($urandom_range(9))
         0: lux = 16'd0;
         1: lux = cur_lux_max;
         2: lux = 16'hFFFF;
         3, 4: lux = LUX_W'($urandom_range(65535));
         default: lux = LUX_W'($urandom_range(int'(cur_lux_max) + int'(cur_lux_max) / 4));
      endcase
      item = make_item(now_ms, lux, $urandom_range(99) < 70, LEVEL_W'($urandom_range(255)));
   endtask

   initial begin
      req_type item;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: interval boundary, lux clamp, manual extremes, time wrap.
      send_item(make_item(32'd0, 16'd500, 1'b1, 8'd0));
      send_item(make_item(32'd999, 16'd500, 1'b1, 8'd0));
      send_item(make_item(32'd1000, 16'd0, 1'b1, 8'd77));
      send_item(make_item(32'd2000, 16'd1000, 1'b1, 8'd0));
      send_item(make_item(32'd3000, 16'hFFFF, 1'b1, 8'hFF));
      send_item(make_item(32'd4000, 16'd12345, 1'b0, 8'd0));
      send_item(make_item(32'd5000, 16'hFFFF, 1'b0, 8'hFF));
      send_item(make_item(32'd5500, 16'd1, 1'b1, 8'd3));
      send_item(make_item(32'hFFFF_FFFF, 16'd500, 1'b1, 8'h55));
      send_item(make_item(32'd500, 16'd800, 1'b1, 8'hAA));
      send_item(make_item(32'd999, 16'd800, 1'b1, 8'hAA));

      // Inverted range with the widest lux scale, updating on every item.
      wait_idle();
      write_config(8'd255, 8'd0, 16'hFFFF, 16'd0);
      send_item(make_item(32'd6000, 16'd0, 1'b1, 8'd0));
      send_item(make_item(32'd6000, 16'h8000, 1'b1, 8'd0));
      send_item(make_item(32'd6000, 16'hFFFF, 1'b1, 8'd0));
      send_item(make_item(32'd6000, 16'd9, 1'b0, 8'd128));
      send_item(make_item(32'd6000, 16'd1, 1'b1, 8'd0));

      // Zero lux_max pins the auto target at auto_max; longest interval.
      wait_idle();
      write_config(8'd0, 8'd255, 16'd0, 16'hFFFF);
      send_item(make_item(32'd6000 + 32'd65534, 16'd7, 1'b1, 8'd0));
      send_item(make_item(32'd6000 + 32'd65535, 16'd7, 1'b1, 8'd0));
      send_item(make_item(32'd6000 + 32'd131070, 16'd7, 1'b0, 8'd0));
      now_ms = 32'd6000 + 32'd131070;

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         wait_idle();
         random_config();
         case (blk / 3)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct <= 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct <= 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         // The sender keeps offering while the result channel is held off.
         if (blk == 0)
            stall_toggle <= ~stall_toggle;
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            random_item(item);
            send_item(item);
            if (blk == 4 && i == BLOCK_ITEMS / 2)
               wait_idle();
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

### ambient_auto_brightness_smoother.f
rtl/absm_pkg.sv
rtl/absm_ctrl.sv
rtl/absm_datapath.sv
rtl/ambient_auto_brightness_smoother.sv
tb/brightness_checker.sv
tb/ambient_auto_brightness_smoother_test.sv
